// File: rtl/core/pdq_pkg.sv
// types and constants shared by the palette dither quantizer modules
package pdq_pkg;

    typedef struct packed {
        logic       func;
        logic [3:0] entry_index;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
        logic [3:0] chosen_index;
        logic       frame_end;
    } out_beat_t;

    typedef struct packed {
        logic pal_write;
        logic capture;
        logic rd_cur;
        logic rd_next;
        logic calc_adj;
        logic search_issue;
        logic finish;
    } pdq_cmd_t;

    typedef struct packed {
        logic search_last;
        logic pipe_busy;
        logic out_free;
    } pdq_status_t;

    typedef enum logic [6:0] {
        ST_IDLE    = 7'b0000001,
        ST_RD_CUR  = 7'b0000010,
        ST_RD_NEXT = 7'b0000100,
        ST_ADJUST  = 7'b0001000,
        ST_SEARCH  = 7'b0010000,
        ST_DRAIN   = 7'b0100000,
        ST_FINISH  = 7'b1000000
    } pdq_state_t;

    localparam logic       FUNC_PIXEL     = 1'b0;
    localparam logic       FUNC_PAL_WRITE = 1'b1;

    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PALETTE_SIZE = 2'd2;

    localparam logic [10:0] WIDTH_RESET  = 11'd640;
    localparam logic [10:0] HEIGHT_RESET = 11'd480;
    localparam logic [4:0]  PSIZE_RESET  = 5'd16;
    localparam logic [10:0] MAX_HEIGHT   = 11'd1024;

endpackage

// File: rtl/core/pdq_ctrl.sv
// sequencer for the palette dither quantizer
module pdq_ctrl
    import pdq_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_func,
    output logic        s_ready,
    input  pdq_status_t status,
    output pdq_cmd_t    cmd
);

    pdq_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next       = state_reg;
        cmd              = '0;
        s_ready          = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_func == FUNC_PAL_WRITE) begin
                        cmd.pal_write = 1'b1;
                    end else begin
                        cmd.capture = 1'b1;
                        state_next  = ST_RD_CUR;
                    end
                end
            end
            ST_RD_CUR: begin
                cmd.rd_cur = 1'b1;
                state_next = ST_RD_NEXT;
            end
            ST_RD_NEXT: begin
                cmd.rd_next = 1'b1;
                state_next  = ST_ADJUST;
            end
            ST_ADJUST: begin
                cmd.calc_adj = 1'b1;
                state_next   = ST_SEARCH;
            end
            ST_SEARCH: begin
                cmd.search_issue = 1'b1;
                if (status.search_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/pdq_datapath.sv
// error diffusion, nearest palette search and output register
module pdq_datapath
    import pdq_pkg::*;
#(
    parameter int MAX_WIDTH     = 1024,
    parameter int PALETTE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  pdq_cmd_t    cmd,
    output pdq_status_t status,
    input  in_beat_t    s_data,
    input  logic [10:0] image_width,
    input  logic [10:0] image_height,
    input  logic [4:0]  palette_size,
    output logic        m_valid,
    input  logic        m_ready,
    output out_beat_t   m_data
);

    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int PW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

    typedef logic signed [8:0] err_t;

    function automatic logic [7:0] adj_chan(
        input logic [7:0] pix,
        input err_t       el,
        input err_t       eul,
        input err_t       eu,
        input err_t       eur,
        input logic       hl,
        input logic       hul,
        input logic       hu,
        input logic       hur
    );
        logic signed [12:0] xl;
        logic signed [12:0] xul;
        logic signed [12:0] xu;
        logic signed [12:0] xur;
        logic signed [12:0] acc;
        logic signed [12:0] v;
        xl  = 13'(el);
        xul = 13'(eul);
        xu  = 13'(eu);
        xur = 13'(eur);
        acc = (hl ? xl * 13'sd7 : 13'sd0) + (hul ? xul : 13'sd0)
            + (hu ? xu * 13'sd5 : 13'sd0) + (hur ? xur * 13'sd3 : 13'sd0);
        v = (acc >>> 4) + $signed({5'b0, pix});
        if (v < 13'sd0) begin
            adj_chan = 8'd0;
        end else if (v > 13'sd255) begin
            adj_chan = 8'd255;
        end else begin
            adj_chan = v[7:0];
        end
    endfunction

    // effective register values
    logic [31:0] w_eff, h_eff, n_eff;
    always_comb begin
        if (image_width == 11'd0) begin
            w_eff = 32'd1;
        end else if ({21'b0, image_width} > 32'(MAX_WIDTH)) begin
            w_eff = 32'(MAX_WIDTH);
        end else begin
            w_eff = {21'b0, image_width};
        end
        if (image_height == 11'd0) begin
            h_eff = 32'd1;
        end else if (image_height > MAX_HEIGHT) begin
            h_eff = {21'b0, MAX_HEIGHT};
        end else begin
            h_eff = {21'b0, image_height};
        end
        if (palette_size == 5'd0) begin
            n_eff = 32'd1;
        end else if ({27'b0, palette_size} > 32'(PALETTE_DEPTH)) begin
            n_eff = 32'(PALETTE_DEPTH);
        end else begin
            n_eff = {27'b0, palette_size};
        end
    end

    // control state
    logic [AW-1:0] col_reg;
    logic [9:0]    row_reg;
    logic [PW-1:0] idx_reg;
    logic          v1_reg, v2_reg;
    logic          m_valid_reg;

    // payload
    in_beat_t      pix_reg;
    logic [23:0]   pal_mem [PALETTE_DEPTH];
    logic [26:0]   row_mem [MAX_WIDTH];
    logic [23:0]   pal_q_reg;
    logic [26:0]   row_q_reg;
    err_t          left_reg [3];
    err_t          win0_reg [3];
    err_t          win1_reg [3];
    logic [7:0]    adj_reg [3];
    logic [PW-1:0] idx1_reg, idx2_reg;
    logic [15:0]   sq_reg [3];
    logic [23:0]   col2_reg;
    logic [17:0]   best_d_reg;
    logic [PW-1:0] best_idx_reg;
    logic [23:0]   best_col_reg;
    out_beat_t     out_reg;

    logic          has_left, has_up, has_ul, has_ur, last_col, last_row;
    logic [AW-1:0] rd_addr;
    logic [17:0]   dist_sum;
    logic          take;
    err_t          urw [3];
    err_t          err_next [3];

    always_comb begin
        has_left = col_reg != '0;
        has_up   = row_reg != '0;
        has_ul   = has_up && has_left;
        has_ur   = has_up && ((32'(col_reg) + 32'd1) < w_eff);
        last_col = (32'(col_reg) + 32'd1) >= w_eff;
        last_row = (32'(row_reg) + 32'd1) >= h_eff;
        rd_addr  = cmd.rd_next ? col_reg + AW'(1) : col_reg;
        dist_sum = 18'(sq_reg[0]) + 18'(sq_reg[1]) + 18'(sq_reg[2]);
        take     = (idx2_reg == '0) || (dist_sum < best_d_reg);
        urw[0]   = row_q_reg[26:18];
        urw[1]   = row_q_reg[17:9];
        urw[2]   = row_q_reg[8:0];
        for (int k = 0; k < 3; k++) begin
            err_next[k] = $signed({1'b0, adj_reg[k]})
                        - $signed({1'b0, best_col_reg[23-8*k -: 8]});
        end
    end

    assign status.search_last = (32'(idx_reg) + 32'd1) >= n_eff;
    assign status.pipe_busy   = v1_reg || v2_reg;
    assign status.out_free    = !m_valid_reg || m_ready;
    assign m_valid            = m_valid_reg;
    assign m_data             = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            idx_reg     <= '0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                left_reg[k] <= '0;
                win0_reg[k] <= '0;
                win1_reg[k] <= '0;
            end
        end else begin
            v1_reg <= cmd.search_issue;
            v2_reg <= v1_reg;
            if (cmd.calc_adj) begin
                idx_reg <= '0;
            end else if (cmd.search_issue) begin
                idx_reg <= idx_reg + PW'(1);
            end
            if (cmd.rd_next) begin
                win1_reg[0] <= urw[0];
                win1_reg[1] <= urw[1];
                win1_reg[2] <= urw[2];
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
                for (int k = 0; k < 3; k++) begin
                    left_reg[k] <= err_next[k];
                    win0_reg[k] <= win1_reg[k];
                end
                if (last_col) begin
                    col_reg <= '0;
                    row_reg <= last_row ? 10'd0 : row_reg + 10'd1;
                end else begin
                    col_reg <= col_reg + AW'(1);
                end
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.pal_write && ({28'b0, s_data.entry_index} < 32'(PALETTE_DEPTH))) begin
            pal_mem[PW'(s_data.entry_index)] <=
                {s_data.red_in, s_data.green_in, s_data.blue_in};
        end
        if (cmd.search_issue) begin
            pal_q_reg <= pal_mem[idx_reg];
        end
        if (cmd.rd_cur || cmd.rd_next) begin
            row_q_reg <= row_mem[rd_addr];
        end
        if (cmd.finish) begin
            row_mem[col_reg] <= {err_next[0], err_next[1], err_next[2]};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            pix_reg <= s_data;
        end
        if (cmd.calc_adj) begin
            adj_reg[0] <= adj_chan(pix_reg.red_in, left_reg[0], win0_reg[0], win1_reg[0],
                                   urw[0], has_left, has_ul, has_up, has_ur);
            adj_reg[1] <= adj_chan(pix_reg.green_in, left_reg[1], win0_reg[1], win1_reg[1],
                                   urw[1], has_left, has_ul, has_up, has_ur);
            adj_reg[2] <= adj_chan(pix_reg.blue_in, left_reg[2], win0_reg[2], win1_reg[2],
                                   urw[2], has_left, has_ul, has_up, has_ur);
        end
        idx1_reg <= idx_reg;
        idx2_reg <= idx1_reg;
        col2_reg <= pal_q_reg;
        for (int k = 0; k < 3; k++) begin
            logic signed [9:0] d;
            logic signed [19:0] p;
            d = $signed({2'b0, adj_reg[k]}) - $signed({2'b0, pal_q_reg[23-8*k -: 8]});
            p = d * d;
            sq_reg[k] <= p[15:0];
        end
        if (v2_reg && take) begin
            best_d_reg   <= dist_sum;
            best_idx_reg <= idx2_reg;
            best_col_reg <= col2_reg;
        end
        if (cmd.finish) begin
            out_reg.red_out      <= best_col_reg[23:16];
            out_reg.green_out    <= best_col_reg[15:8];
            out_reg.blue_out     <= best_col_reg[7:0];
            out_reg.alpha_out    <= pix_reg.alpha_in;
            out_reg.chosen_index <= 4'(best_idx_reg);
            out_reg.frame_end    <= last_col && last_row;
        end
    end

endmodule

// File: rtl/core/palette_dither_quantizer_top.sv
// palette dither quantizer: top level with configuration registers
//
// input beats carry either a palette write (func = 1, slot entry_index) or an
// rgba pixel in raster order (func = 0); a palette write makes no result beat.
// each pixel gets diffused error from its left, upper-left, upper and
// upper-right neighbours, is clamped, and is mapped to the nearest palette
// entry; one result beat per pixel carries colour, index, alpha and frame_end
// on the last pixel of a frame.
// a pixel goes from accept to result through two row-buffer reads, an adjust
// step, one palette entry per cycle through the distance pipeline, a drain of
// that pipeline and a write-back step.
// one pixel is worked on at a time; the next beat is accepted once the result
// sits in the output register, which holds it while m_ready is low.
// the apb port (psel/penable/pwrite/paddr/pwdata/prdata/pready) holds
// image_width at 0x0, image_height at 0x4 and palette_size at 0x8.
// reset (aresetn low, synchronous) restores 640 x 480 and 16 entries, clears
// the row and column position and the held error; the palette and row buffer
// must be written before they are read.
module palette_dither_quantizer_top
    import pdq_pkg::*;
#(
    parameter int MAX_WIDTH     = 1024,
    parameter int PALETTE_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_beat_t    s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_beat_t   m_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [4:0]  psize_reg;
    pdq_cmd_t    cmd;
    pdq_status_t status;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            psize_reg  <= PSIZE_RESET;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[10:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[10:0];
                REG_PALETTE_SIZE: psize_reg  <= pwdata[4:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_IMAGE_WIDTH:  prdata = {21'b0, width_reg};
            REG_IMAGE_HEIGHT: prdata = {21'b0, height_reg};
            REG_PALETTE_SIZE: prdata = {27'b0, psize_reg};
            default:          prdata = '0;
        endcase
    end

    pdq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_data.func),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pdq_datapath #(
        .MAX_WIDTH     (MAX_WIDTH),
        .PALETTE_DEPTH (PALETTE_DEPTH)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_data       (s_data),
        .image_width  (width_reg),
        .image_height (height_reg),
        .palette_size (psize_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

endmodule

// File: tb/sv/tb_top.sv
// testbench for the palette dither quantizer: nearest-colour prediction and result checks
`timescale 1ns / 1ps

class dither_scoreboard;
    logic [7:0]  pal [16][3];
    int          row_err [1024][3];
    int          left_err [3];
    int          upl_err [3];
    int          col;
    int          row;
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [4:0]  psize_reg;
    pdq_pkg::out_beat_t expected_q [$];
    int          errors;

    function new();
        foreach (pal[i, j]) pal[i][j] = 8'd0;
        foreach (row_err[i, j]) row_err[i][j] = 0;
        foreach (left_err[j]) begin
            left_err[j] = 0;
            upl_err[j] = 0;
        end
        col = 0;
        row = 0;
        width_reg = pdq_pkg::WIDTH_RESET;
        height_reg = pdq_pkg::HEIGHT_RESET;
        psize_reg = pdq_pkg::PSIZE_RESET;
        errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] val);
        case (idx)
            pdq_pkg::REG_IMAGE_WIDTH:  width_reg = val[10:0];
            pdq_pkg::REG_IMAGE_HEIGHT: height_reg = val[10:0];
            pdq_pkg::REG_PALETTE_SIZE: psize_reg = val[4:0];
            default: ;
        endcase
    endfunction

    function void note(pdq_pkg::in_beat_t b);
        int w, h, n, best, best_d, d, diff, acc, v;
        int adj [3];
        int up_cur [3];
        int up_nxt [3];
        int pix [3];
        bit last_col;
        pdq_pkg::out_beat_t o;
        if (b.func == pdq_pkg::FUNC_PAL_WRITE) begin
            pal[b.entry_index][0] = b.red_in;
            pal[b.entry_index][1] = b.green_in;
            pal[b.entry_index][2] = b.blue_in;
            return;
        end
        w = (width_reg < 1) ? 1 : (width_reg > 1024) ? 1024 : int'(width_reg);
        h = (height_reg < 1) ? 1 : (height_reg > 1024) ? 1024 : int'(height_reg);
        n = (psize_reg < 1) ? 1 : (psize_reg > 16) ? 16 : int'(psize_reg);
        pix[0] = int'(b.red_in);
        pix[1] = int'(b.green_in);
        pix[2] = int'(b.blue_in);
        for (int ch = 0; ch < 3; ch++) begin
            up_cur[ch] = row_err[col][ch];
            up_nxt[ch] = (col + 1 < 1024) ? row_err[col + 1][ch] : 0;
            acc = 0;
            if (col > 0) acc += 7 * left_err[ch];
            if (row > 0 && col > 0) acc += upl_err[ch];
            if (row > 0) acc += 5 * up_cur[ch];
            if (row > 0 && col + 1 < w) acc += 3 * up_nxt[ch];
            v = ((acc + 4096) >>> 4) - 256 + pix[ch];
            adj[ch] = (v < 0) ? 0 : (v > 255) ? 255 : v;
        end
        best = 0;
        best_d = 0;
        for (int i = 0; i < n; i++) begin
            d = 0;
            for (int ch = 0; ch < 3; ch++) begin
                diff = adj[ch] - int'(pal[i][ch]);
                d += diff * diff;
            end
            if (i == 0 || d < best_d) begin
                best_d = d;
                best = i;
            end
        end
        for (int ch = 0; ch < 3; ch++) begin
            upl_err[ch] = up_cur[ch];
            row_err[col][ch] = adj[ch] - int'(pal[best][ch]);
            left_err[ch] = row_err[col][ch];
        end
        last_col = (col + 1 >= w);
        o.red_out = pal[best][0];
        o.green_out = pal[best][1];
        o.blue_out = pal[best][2];
        o.alpha_out = b.alpha_in;
        o.chosen_index = best[3:0];
        o.frame_end = last_col && (row + 1 >= h);
        expected_q = {expected_q, o};
        if (last_col) begin
            col = 0;
            row = (row + 1 >= h) ? 0 : row + 1;
        end else begin
            col = col + 1;
        end
    endfunction

    function void check(pdq_pkg::out_beat_t a);
        pdq_pkg::out_beat_t e;
        if (expected_q.size() == 0) begin
            $display("%0t: unexpected result beat %h", $realtime, a);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        if (a.red_out !== e.red_out)
            $display("%0t: red_out expected %0d actual %0d", $realtime, e.red_out, a.red_out);
        if (a.green_out !== e.green_out)
            $display("%0t: green_out expected %0d actual %0d", $realtime, e.green_out,
                     a.green_out);
        if (a.blue_out !== e.blue_out)
            $display("%0t: blue_out expected %0d actual %0d", $realtime, e.blue_out, a.blue_out);
        if (a.alpha_out !== e.alpha_out)
            $display("%0t: alpha_out expected %0d actual %0d", $realtime, e.alpha_out,
                     a.alpha_out);
        if (a.chosen_index !== e.chosen_index)
            $display("%0t: chosen_index expected %0d actual %0d", $realtime, e.chosen_index,
                     a.chosen_index);
        if (a.frame_end !== e.frame_end)
            $display("%0t: frame_end expected %0d actual %0d", $realtime, e.frame_end,
                     a.frame_end);
        if (a !== e) errors++;
    endfunction
endclass

module tb_top;
    import pdq_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_beat_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_beat_t   m_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dither_scoreboard sb;
    bit quiet;
    int stall_cnt;
    int idle_cycles;
    int sent;
    out_beat_t m_snap;

    palette_dither_quantizer_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // s_ready only changes at the rising edge, so its value at the falling edge holds
    task automatic send_beat(in_beat_t b);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat ($urandom_range(0, 7)) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid = 1'b1;
        s_data = b;
        while (!s_ready) @(negedge aclk);
        @(posedge aclk);
        sb.note(b);
        sent++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        s_valid = 1'b0;
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = val;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, val);
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic send_pal(int idx, int r, int g, int b);
        in_beat_t x;
        x = '0;
        x.func = FUNC_PAL_WRITE;
        x.entry_index = 4'(idx);
        x.red_in = 8'(r);
        x.green_in = 8'(g);
        x.blue_in = 8'(b);
        x.alpha_in = 8'($urandom);
        send_beat(x);
    endtask

    task automatic send_pix(int r, int g, int b, int a);
        in_beat_t x;
        x.func = FUNC_PIXEL;
        x.entry_index = 4'($urandom);
        x.red_in = 8'(r);
        x.green_in = 8'(g);
        x.blue_in = 8'(b);
        x.alpha_in = 8'(a);
        send_beat(x);
    endtask

    task automatic new_frame_config();
        int sel;
        wait_drained();
        sel = $urandom_range(0, 9);
        write_reg(REG_IMAGE_WIDTH, sel == 0 ? 0 : sel == 1 ? 24 : $urandom_range(1, 8));
        write_reg(REG_IMAGE_HEIGHT, sel == 2 ? 0 : $urandom_range(1, 5));
        sel = $urandom_range(0, 9);
        write_reg(REG_PALETTE_SIZE, sel == 0 ? 0 : sel == 1 ? 31 : sel == 2 ? 1 :
                  $urandom_range(1, 16));
    endtask

    initial begin
        sb = new();
        quiet = 1'b0;
        sent = 0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // palette with black, white, primaries and a duplicate pair for ties
        for (int i = 0; i < 16; i++) begin
            case (i)
                0: send_pal(i, 0, 0, 0);
                1: send_pal(i, 255, 255, 255);
                2: send_pal(i, 255, 0, 0);
                3: send_pal(i, 0, 255, 0);
                4: send_pal(i, 0, 255, 0);
                5: send_pal(i, 0, 0, 255);
                default: send_pal(i, $urandom, $urandom, $urandom);
            endcase
        end
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, 3);
        write_reg(REG_IMAGE_HEIGHT, 2);
        write_reg(REG_PALETTE_SIZE, 16);
        send_pix(0, 0, 0, 0);
        send_pix(255, 255, 255, 255);
        send_pix(0, 255, 0, 170);
        send_pix(255, 0, 0, 85);
        send_pix(0, 0, 255, 255);
        send_pix(128, 128, 128, 0);

        while (sent < 700 || sb.col != 0 || sb.row != 0) begin
            if (sent >= 650) quiet = 1'b1;
            if (sb.col == 0 && sb.row == 0 && $urandom_range(0, 3) == 0)
                new_frame_config();
            if ($urandom_range(0, 9) == 0) begin
                send_pal($urandom_range(0, 15), $urandom, $urandom, $urandom);
            end else if ($urandom_range(0, 7) == 0) begin
                send_pix($urandom_range(0, 1) * 255, $urandom_range(0, 1) * 255,
                         $urandom_range(0, 1) * 255, $urandom);
            end else begin
                send_pix($urandom, $urandom, $urandom, $urandom);
            end
        end

        // out-of-range values saturate to a full-width single row
        wait_drained();
        write_reg(REG_IMAGE_WIDTH, 2047);
        write_reg(REG_IMAGE_HEIGHT, 0);
        write_reg(REG_PALETTE_SIZE, 31);
        for (int i = 0; i < 40; i++) send_pix($urandom, $urandom, $urandom, $urandom);

        @(negedge aclk);
        s_valid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("palette_dither_quantizer_top verification clean");
        end else begin
            $display("palette_dither_quantizer_top verification failed");
        end
        $finish;
    end

    // m_valid and m_data only change at the rising edge, so the beat is taken before it
    initial begin
        m_ready = 1'b0;
        idle_cycles = 0;
        forever begin
            @(negedge aclk);
            if (idle_cycles > 0) begin
                idle_cycles--;
                m_ready = 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                idle_cycles = $urandom_range(0, 7);
                m_ready = 1'b0;
            end else begin
                m_ready = 1'b1;
            end
            if (aresetn && m_valid && m_ready) begin
                m_snap = m_data;
                @(posedge aclk);
                sb.check(m_snap);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            stall_cnt <= 0;
        end else if (stall_cnt >= 5000) begin
            $display("palette_dither_quantizer_top verification failed");
            $finish;
        end else begin
            stall_cnt <= stall_cnt + 1;
        end
    end

endmodule

// File: files.f
rtl/core/pdq_pkg.sv
rtl/core/pdq_ctrl.sv
rtl/core/pdq_datapath.sv
rtl/core/palette_dither_quantizer_top.sv
tb/sv/tb_top.sv
